>>> hdl/llpf_pkg.sv
// ----------------------------------------------------------------------------
// Longest letter palindrome finder package
// Shared sizes, request/result payload types and letter helpers.
// ----------------------------------------------------------------------------
package llpf_pkg;

  // Text capacity in bytes
  localparam int MAX_TEXT = 32768;
  // Address width of the letter stores
  localparam int ADDR_W   = $clog2(MAX_TEXT);
  // Counter width, able to hold MAX_TEXT itself
  localparam int CNT_W    = $clog2(MAX_TEXT + 1);
  // Folded letter code: 'a'..'z' as 0..25
  localparam int FOLD_W   = 5;

  localparam logic [7:0] CH_LO_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UP_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z = 8'h5A;  // 'Z'

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] pal_length;
    logic [14:0] start_pos;
    logic [14:0] end_pos;
    logic        overflow;
  } out_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
  endfunction

  // Map either case to a 0..25 code (only meaningful for letters)
  function automatic logic [FOLD_W-1:0] fold_letter(input logic [7:0] c);
    logic [7:0] low;
    low = (c | 8'h20) - CH_LO_A;
    return low[FOLD_W-1:0];
  endfunction

endpackage

>>> hdl/llpf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module llpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/longest_letter_palindrome_finder_core.sv
// ----------------------------------------------------------------------------
// Longest letter palindrome finder core
// Loads a text, then finds its longest case-blind palindrome over letters only.
// ----------------------------------------------------------------------------
// Text bytes are taken one per cycle while loading; each letter's folded code
// and text position go into two 32768-entry memories. The request marked
// final starts the search and input stalls until the result is registered.
// The search expands around every odd and even center (2n-1 centers for n
// letters) with one compare unit fed by the two read ports of the letter
// memory: each center has a setup step, a read and a compare step per
// matching letter pair and a last read, or read and compare, to stop; the
// search time thus grows with the sum of all palindrome radii (that sum
// reaches about n*n/2 for one repeated letter). The end positions are then
// looked up. No clearing pass is needed after reset. Ties go to the earliest
// start; a text with no letters gives length 0. Bytes beyond capacity are
// dropped and the overflow bit is set.
module longest_letter_palindrome_finder_core
  import llpf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CENTER,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_POS_RD,
    ST_POS_CAP
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   text_cnt_r, text_cnt_nxt;
  logic [CNT_W-1:0]   letter_cnt_r, letter_cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W:0]     ctr_r, ctr_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [CNT_W-1:0]   cur_len_r, cur_len_nxt;
  logic [CNT_W-1:0]   best_len_r, best_len_nxt;
  logic [CNT_W-1:0]   best_start_r, best_start_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               room;
  logic               wr_en;
  logic [FOLD_W-1:0]  fold_a, fold_b;
  logic [ADDR_W-1:0]  pos_a, pos_b;
  logic [CNT_W-1:0]   lo_m1;
  logic [CNT_W-1:0]   end_idx;
  logic [CNT_W-1:0]   ctr_half;
  logic               better;

  assign room     = text_cnt_r < CNT_W'(MAX_TEXT);
  assign wr_en    = (state_r == ST_LOAD) && in_valid && room && is_letter(in_data.text_byte);
  assign lo_m1    = lo_r - CNT_W'(1);
  assign end_idx  = best_start_r + best_len_r - CNT_W'(1);
  assign ctr_half = ctr_r[CNT_W:1];

  // Current center beats the best so far
  assign better = (cur_len_r != '0) &&
                  ((cur_len_r > best_len_r) ||
                   ((cur_len_r == best_len_r) && (lo_r < best_start_r)));

  // Folded letters, read just outside both ends of the current span
  llpf_ram #(.WIDTH(FOLD_W), .DEPTH(MAX_TEXT)) u_fold_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (letter_cnt_r[ADDR_W-1:0]),
    .wdata   (fold_letter(in_data.text_byte)),
    .raddr_a (lo_m1[ADDR_W-1:0]),
    .rdata_a (fold_a),
    .raddr_b (hi_r[ADDR_W-1:0]),
    .rdata_b (fold_b)
  );

  // Text positions of letters, read at first and last letter of the winner
  llpf_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_TEXT)) u_pos_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (letter_cnt_r[ADDR_W-1:0]),
    .wdata   (text_cnt_r[ADDR_W-1:0]),
    .raddr_a (best_start_r[ADDR_W-1:0]),
    .rdata_a (pos_a),
    .raddr_b (end_idx[ADDR_W-1:0]),
    .rdata_b (pos_b)
  );

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    text_cnt_nxt   = text_cnt_r;
    letter_cnt_nxt = letter_cnt_r;
    ovf_nxt        = ovf_r;
    ctr_nxt        = ctr_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    cur_len_nxt    = cur_len_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (room) begin
            text_cnt_nxt = text_cnt_r + CNT_W'(1);
            if (is_letter(in_data.text_byte)) begin
              letter_cnt_nxt = letter_cnt_r + CNT_W'(1);
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.final_byte) begin
            ctr_nxt        = '0;
            best_len_nxt   = '0;
            best_start_nxt = '0;
            state_nxt      = ST_CENTER;
          end
        end
      end

      // Set up the span for the next center, or finish
      ST_CENTER: begin
        if ((ctr_r + (CNT_W+1)'(1)) >= {letter_cnt_r, 1'b0}) begin
          state_nxt = ST_POS_RD;
        end else begin
          hi_nxt = ctr_half + CNT_W'(1);
          if (ctr_r[0]) begin
            lo_nxt      = ctr_half + CNT_W'(1);
            cur_len_nxt = '0;
          end else begin
            lo_nxt      = ctr_half;
            cur_len_nxt = CNT_W'(1);
          end
          state_nxt = ST_EXP_RD;
        end
      end

      // Read both neighbors if still inside the letter sequence
      ST_EXP_RD: begin
        if ((lo_r != '0) && (hi_r < letter_cnt_r)) begin
          state_nxt = ST_EXP_CMP;
        end else begin
          if (better) begin
            best_len_nxt   = cur_len_r;
            best_start_nxt = lo_r;
          end
          ctr_nxt   = ctr_r + (CNT_W+1)'(1);
          state_nxt = ST_CENTER;
        end
      end

      // Grow the span on a match, else close this center
      ST_EXP_CMP: begin
        if (fold_a == fold_b) begin
          cur_len_nxt = cur_len_r + CNT_W'(2);
          lo_nxt      = lo_m1;
          hi_nxt      = hi_r + CNT_W'(1);
          state_nxt   = ST_EXP_RD;
        end else begin
          if (better) begin
            best_len_nxt   = cur_len_r;
            best_start_nxt = lo_r;
          end
          ctr_nxt   = ctr_r + (CNT_W+1)'(1);
          state_nxt = ST_CENTER;
        end
      end

      ST_POS_RD: begin
        state_nxt = ST_POS_CAP;
      end

      // Register the result once the output side is free, then reload
      ST_POS_CAP: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.pal_length = best_len_r;
          out_data_nxt.start_pos  = (best_len_r == '0) ? '0 : pos_a;
          out_data_nxt.end_pos    = (best_len_r == '0) ? '0 : pos_b;
          out_data_nxt.overflow   = ovf_r;
          out_valid_nxt           = 1'b1;
          text_cnt_nxt            = '0;
          letter_cnt_nxt          = '0;
          ovf_nxt                 = 1'b0;
          state_nxt               = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      text_cnt_r   <= '0;
      letter_cnt_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      text_cnt_r   <= text_cnt_nxt;
      letter_cnt_r <= letter_cnt_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ctr_r        <= ctr_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    cur_len_r    <= cur_len_nxt;
    best_len_r   <= best_len_nxt;
    best_start_r <= best_start_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Letters never outnumber stored bytes
  a_letters_le_text: assert property (@(posedge clk) disable iff (!rst_n)
    letter_cnt_r <= text_cnt_r)
    else $error("letter count exceeds text count");

  // Stored byte count stays within capacity
  a_text_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    text_cnt_r <= CNT_W'(MAX_TEXT))
    else $error("text count beyond capacity");

  // An empty result carries zero positions
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.pal_length == '0)) |->
    ((out_data.start_pos == '0) && (out_data.end_pos == '0)))
    else $error("empty result with nonzero positions");

  // A found palindrome ends no earlier than it starts
  a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.pal_length != '0)) |->
    (out_data.start_pos <= out_data.end_pos))
    else $error("palindrome end before start");

endmodule
